FILE: rtl/core/complex_arithmetic_unit_defines.svh
// Assertion macros for the complex arithmetic unit.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("complex_arithmetic_unit check failed");
// next-cycle implication
`define CAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("complex_arithmetic_unit check failed");
`else
`define CAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/cau_pkg.sv
// Shared constants for the complex arithmetic unit: widths, opcodes,
// register map. No dependencies.
package cau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DW            = 32;  // operand / result part width
  localparam int KIND_W        = 3;
  localparam int TOL_W         = 16;
  localparam int PDATA_W       = 32;
  localparam int PADDR_W       = 3;
  localparam int QB            = 34;  // quotient bits per divide lane

  localparam logic [KIND_W-1:0] OP_ADD = 3'd0;
  localparam logic [KIND_W-1:0] OP_SUB = 3'd1;
  localparam logic [KIND_W-1:0] OP_MUL = 3'd2;
  localparam logic [KIND_W-1:0] OP_DIV = 3'd3;
  localparam logic [KIND_W-1:0] OP_EQ  = 3'd4;
  localparam logic [KIND_W-1:0] OP_NE  = 3'd5;

  localparam logic [PADDR_W-3:0] REG_TOL   = 1'b0;
  localparam logic [TOL_W-1:0]   TOL_RESET = 16'd1;

endpackage

FILE: rtl/core/complex_arithmetic_unit.sv
// Complex arithmetic unit top level: pipelined add/sub/mul/div/compare.
// Depends on cau_pkg and complex_arithmetic_unit_defines.svh.
//
// Usage:
//   Input channel in_valid/in_stall carries an opcode (in_kind) and two
//   complex Q-format operands A = in_a_real + j*in_a_imag and
//   B = in_b_real + j*in_b_imag. Each accepted item yields exactly one
//   result item on out_valid/out_stall: res_real, res_imag, compare_true,
//   div_by_zero and overflow.
//   Between accept and out_valid lie three stages of multiply and sum,
//   one stage of rounding and divider setup, 34 stages of a restoring
//   divider (one quotient bit per stage per lane), and the output register.
//   Throughput is one item per cycle while out_stall does not hold the pipe;
//   every opcode goes through the same pipe so results come out in order.
//   The whole pipe advances together; when a result is held by out_stall
//   the pipe freezes and in_stall rises in the same cycle. Nothing is
//   lost or repeated.
//   Reset (rst_n low, synchronous) empties the pipe and sets the equal
//   tolerance register to 1. The tolerance is written over the APB-style
//   port at byte address 0; the user must write it only while the unit is idle, the block does not enforce this.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cau_pkg::KIND_W-1:0]    in_kind,
  input  logic signed [cau_pkg::DW-1:0] in_a_real,
  input  logic signed [cau_pkg::DW-1:0] in_a_imag,
  input  logic signed [cau_pkg::DW-1:0] in_b_real,
  input  logic signed [cau_pkg::DW-1:0] in_b_imag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [cau_pkg::DW-1:0] out_res_real,
  output logic signed [cau_pkg::DW-1:0] out_res_imag,
  output logic                          out_compare_true,
  output logic                          out_div_by_zero,
  output logic                          out_overflow,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [cau_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [cau_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [cau_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import cau_pkg::*;
  `include "complex_arithmetic_unit_defines.svh"

  localparam int NW = 64 + FRAC_BITS + 1;  // shifted numerator width
  localparam logic [64:0] HALF = (65'd1 << FRAC_BITS) >> 1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [63:0]       ac, bd, ad, bc, cc, dd;
    logic [32:0]       sum_re, sum_im;
    logic              dz;
  } s1_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [64:0]       mre, mim, nre, nim;
    logic [63:0]       den;
    logic [32:0]       sum_re, sum_im;
    logic              eq;
    logic              dz;
  } s2_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              mre_neg, mim_neg, nre_neg, nim_neg;
    logic [63:0]       mre_mag, mim_mag, nre_mag, nim_mag;
    logic [63:0]       den;
    logic [32:0]       sum_re, sum_im;
    logic              eq;
    logic              dz;
  } s3_t;

  typedef struct packed {
    logic          neg;
    logic          sat;
    logic [63:0]   rem;
    logic [QB-1:0] nlo;
    logic [QB-1:0] q;
  } lane_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              dz;
    logic [DW-1:0]     sre, sim;
    logic              scmp;
    logic              sovf;
    logic [63:0]       den;
    lane_t             re, im;
  } dv_t;

  typedef struct packed {
    logic          ovf;
    logic [DW-1:0] val;
  } sat_t;

  function automatic sat_t sat_mag(input logic neg, input logic [64:0] mag);
    sat_t s;
    s.ovf = 1'b0;
    if (neg) begin
      if (mag > 65'h0_8000_0000) begin
        s.ovf = 1'b1;
        s.val = 32'h8000_0000;
      end else begin
        s.val = DW'(65'd0 - mag);
      end
    end else begin
      if (mag > 65'h0_7FFF_FFFF) begin
        s.ovf = 1'b1;
        s.val = 32'h7FFF_FFFF;
      end else begin
        s.val = mag[DW-1:0];
      end
    end
    return s;
  endfunction

  function automatic sat_t sat_sum(input logic [32:0] sum);
    sat_t s;
    s.ovf = sum[32] ^ sum[31];
    if (s.ovf) begin
      s.val = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      s.val = sum[DW-1:0];
    end
    return s;
  endfunction

  function automatic lane_t div_step(input lane_t l, input logic [63:0] den);
    lane_t       o;
    logic [64:0] r2;
    o  = l;
    r2 = {l.rem, l.nlo[QB-1]};
    o.nlo = {l.nlo[QB-2:0], 1'b0};
    if (r2 >= {1'b0, den}) begin
      o.rem = 64'(r2 - {1'b0, den});
      o.q   = {l.q[QB-2:0], 1'b1};
    end else begin
      o.rem = r2[63:0];
      o.q   = {l.q[QB-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic lane_t div_init(input logic neg, input logic [63:0] mag,
                                     input logic [63:0] den);
    lane_t         l;
    logic [NW-1:0] nsh;
    logic [64:0]   r0;
    nsh   = {mag, {(FRAC_BITS + 1){1'b0}}};
    r0    = 65'(nsh[NW-1:QB]);
    l.neg = neg;
    l.sat = (r0 >= {1'b0, den});  // quotient needs more than QB bits
    l.rem = r0[63:0];
    l.nlo = nsh[QB-1:0];
    l.q   = '0;
    return l;
  endfunction

  // ---------------------------------------------------------------- config
  logic [TOL_W-1:0]   tol_r;
  logic [PADDR_W-3:0] cfg_idx;

  assign cfg_idx    = cfg_paddr[PADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_idx == REG_TOL) ? PDATA_W'(tol_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_idx == REG_TOL) begin
      tol_r <= cfg_pwdata[TOL_W-1:0];
    end
  end

  // ------------------------------------------------------------ flow control
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // ---------------------------------------------------------------- stage 1
  s1_t  s1_r, s1_nxt;
  logic s1_v_r;
  logic signed [63:0] p_ac, p_bd, p_ad, p_bc, p_cc, p_dd;

  assign p_ac = in_a_real * in_b_real;
  assign p_bd = in_a_imag * in_b_imag;
  assign p_ad = in_a_real * in_b_imag;
  assign p_bc = in_a_imag * in_b_real;
  assign p_cc = in_b_real * in_b_real;
  assign p_dd = in_b_imag * in_b_imag;

  always_comb begin
    s1_nxt.kind = in_kind;
    s1_nxt.ac   = p_ac;
    s1_nxt.bd   = p_bd;
    s1_nxt.ad   = p_ad;
    s1_nxt.bc   = p_bc;
    s1_nxt.cc   = p_cc;
    s1_nxt.dd   = p_dd;
    // subtract and compare share the difference
    if (in_kind == OP_ADD) begin
      s1_nxt.sum_re = {in_a_real[DW-1], in_a_real} + {in_b_real[DW-1], in_b_real};
      s1_nxt.sum_im = {in_a_imag[DW-1], in_a_imag} + {in_b_imag[DW-1], in_b_imag};
    end else begin
      s1_nxt.sum_re = {in_a_real[DW-1], in_a_real} - {in_b_real[DW-1], in_b_real};
      s1_nxt.sum_im = {in_a_imag[DW-1], in_a_imag} - {in_b_imag[DW-1], in_b_imag};
    end
    s1_nxt.dz = (in_b_real == '0) && (in_b_imag == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  s2_t         s2_r, s2_nxt;
  logic        s2_v_r;
  logic [32:0] abs_re, abs_im;

  always_comb begin
    abs_re = s1_r.sum_re[32] ? 33'd0 - s1_r.sum_re : s1_r.sum_re;
    abs_im = s1_r.sum_im[32] ? 33'd0 - s1_r.sum_im : s1_r.sum_im;
    s2_nxt.kind   = s1_r.kind;
    s2_nxt.mre    = {s1_r.ac[63], s1_r.ac} - {s1_r.bd[63], s1_r.bd};
    s2_nxt.mim    = {s1_r.ad[63], s1_r.ad} + {s1_r.bc[63], s1_r.bc};
    s2_nxt.nre    = {s1_r.ac[63], s1_r.ac} + {s1_r.bd[63], s1_r.bd};
    s2_nxt.nim    = {s1_r.bc[63], s1_r.bc} - {s1_r.ad[63], s1_r.ad};
    s2_nxt.den    = s1_r.cc + s1_r.dd;
    s2_nxt.sum_re = s1_r.sum_re;
    s2_nxt.sum_im = s1_r.sum_im;
    s2_nxt.eq     = (abs_re < 33'(tol_r)) && (abs_im < 33'(tol_r));
    s2_nxt.dz     = s1_r.dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 3
  s3_t  s3_r, s3_nxt;
  logic s3_v_r;

  always_comb begin
    s3_nxt.kind    = s2_r.kind;
    s3_nxt.mre_neg = s2_r.mre[64];
    s3_nxt.mim_neg = s2_r.mim[64];
    s3_nxt.nre_neg = s2_r.nre[64];
    s3_nxt.nim_neg = s2_r.nim[64];
    s3_nxt.mre_mag = 64'(s2_r.mre[64] ? 65'd0 - s2_r.mre : s2_r.mre);
    s3_nxt.mim_mag = 64'(s2_r.mim[64] ? 65'd0 - s2_r.mim : s2_r.mim);
    s3_nxt.nre_mag = 64'(s2_r.nre[64] ? 65'd0 - s2_r.nre : s2_r.nre);
    s3_nxt.nim_mag = 64'(s2_r.nim[64] ? 65'd0 - s2_r.nim : s2_r.nim);
    s3_nxt.den     = s2_r.den;
    s3_nxt.sum_re  = s2_r.sum_re;
    s3_nxt.sum_im  = s2_r.sum_im;
    s3_nxt.eq      = s2_r.eq;
    s3_nxt.dz      = s2_r.dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r <= s3_nxt;
    end
  end

  // ------------------------------------- stage 4: rounding, side result, div setup
  dv_t         dp_r [0:QB];
  logic        dp_v_r [0:QB];
  dv_t         dp0_nxt;
  logic [64:0] mr_re, mr_im;
  sat_t        sm_re, sm_im, sa_re, sa_im;

  always_comb begin
    mr_re = ({1'b0, s3_r.mre_mag} + HALF) >> FRAC_BITS;
    mr_im = ({1'b0, s3_r.mim_mag} + HALF) >> FRAC_BITS;
    sm_re = sat_mag(s3_r.mre_neg, mr_re);
    sm_im = sat_mag(s3_r.mim_neg, mr_im);
    sa_re = sat_sum(s3_r.sum_re);
    sa_im = sat_sum(s3_r.sum_im);

    dp0_nxt.kind = s3_r.kind;
    dp0_nxt.dz   = s3_r.dz;
    dp0_nxt.den  = s3_r.den;
    dp0_nxt.sre  = '0;
    dp0_nxt.sim  = '0;
    dp0_nxt.scmp = 1'b0;
    dp0_nxt.sovf = 1'b0;
    unique case (s3_r.kind)
      OP_ADD, OP_SUB: begin
        dp0_nxt.sre  = sa_re.val;
        dp0_nxt.sim  = sa_im.val;
        dp0_nxt.sovf = sa_re.ovf | sa_im.ovf;
      end
      OP_MUL: begin
        dp0_nxt.sre  = sm_re.val;
        dp0_nxt.sim  = sm_im.val;
        dp0_nxt.sovf = sm_re.ovf | sm_im.ovf;
      end
      OP_EQ:   dp0_nxt.scmp = s3_r.eq;
      OP_NE:   dp0_nxt.scmp = !s3_r.eq;
      default: dp0_nxt.scmp = 1'b0;  // divide and unused codes
    endcase
    dp0_nxt.re = div_init(s3_r.nre_neg, s3_r.nre_mag, s3_r.den);
    dp0_nxt.im = div_init(s3_r.nim_neg, s3_r.nim_mag, s3_r.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_v_r[0] <= 1'b0;
    end else if (adv) begin
      dp_v_r[0] <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dp_r[0] <= dp0_nxt;
    end
  end

  // ----------------------------------------- divider: one quotient bit a stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    dv_t step_nxt;

    always_comb begin
      step_nxt    = dp_r[k];
      step_nxt.re = div_step(dp_r[k].re, dp_r[k].den);
      step_nxt.im = div_step(dp_r[k].im, dp_r[k].den);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dp_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dp_v_r[k+1] <= dp_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dp_r[k+1] <= step_nxt;
      end
    end
  end

  // ------------------------------------------------------- output register
  dv_t           fin;
  logic [QB:0]   qr_re, qr_im;
  sat_t          sd_re, sd_im;
  logic [DW-1:0] res_re_nxt, res_im_nxt;
  logic          cmp_nxt, dz_nxt, ovf_nxt;
  logic [DW-1:0] res_re_r, res_im_r;
  logic          cmp_r, dz_r, ovf_r;

  always_comb begin
    fin   = dp_r[QB];
    qr_re = {1'b0, fin.re.q} + 1'b1;
    qr_im = {1'b0, fin.im.q} + 1'b1;
    sd_re = sat_mag(fin.re.neg, fin.re.sat ? {1'b1, 64'd0} : 65'(qr_re[QB:1]));
    sd_im = sat_mag(fin.im.neg, fin.im.sat ? {1'b1, 64'd0} : 65'(qr_im[QB:1]));
    if (fin.kind == OP_DIV && !fin.dz) begin
      res_re_nxt = sd_re.val;
      res_im_nxt = sd_im.val;
      ovf_nxt    = sd_re.ovf | sd_im.ovf;
      cmp_nxt    = 1'b0;
      dz_nxt     = 1'b0;
    end else begin
      res_re_nxt = fin.sre;
      res_im_nxt = fin.sim;
      ovf_nxt    = fin.sovf;
      cmp_nxt    = fin.scmp;
      dz_nxt     = (fin.kind == OP_DIV);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dp_v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      cmp_r    <= cmp_nxt;
      dz_r     <= dz_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_res_real     = res_re_r;
  assign out_res_imag     = res_im_r;
  assign out_compare_true = cmp_r;
  assign out_div_by_zero  = dz_r;
  assign out_overflow     = ovf_r;

  // ---------------------------------------------------------------- checks
  `CAU_ASSERT_NXT(a_accept_enters, clk, rst_n, in_valid && !in_stall, s1_v_r)
  `CAU_ASSERT_IMP(a_dz_zero, clk, rst_n, out_valid && out_div_by_zero,
                  out_res_real == '0 && out_res_imag == '0 && !out_overflow)
  `CAU_ASSERT_IMP(a_cmp_clean, clk, rst_n, out_valid && out_compare_true,
                  out_res_real == '0 && out_res_imag == '0 &&
                  !out_overflow && !out_div_by_zero)
  `CAU_ASSERT_IMP(a_ovf_limit, clk, rst_n, out_valid && out_overflow,
                  out_res_real == 32'h7FFF_FFFF || out_res_real == 32'h8000_0000 ||
                  out_res_imag == 32'h7FFF_FFFF || out_res_imag == 32'h8000_0000)

endmodule

FILE: verif/tb_complex_arithmetic_unit.sv
// Self-checking testbench for complex_arithmetic_unit: a queue-fed driver,
// an output monitor with a bit-exact predictor, and APB tolerance writes.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int FB = FRAC_BITS_DEF;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic signed [DW-1:0] ar, ai, br, bi;
  } op_item_t;

  typedef struct packed {
    logic signed [DW-1:0] re, im;
    logic                 cmp, dz, ovf;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] in_kind = '0;
  logic signed [DW-1:0] in_a_real = '0, in_a_imag = '0, in_b_real = '0, in_b_imag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DW-1:0] out_res_real, out_res_imag;
  logic out_compare_true, out_div_by_zero, out_overflow;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [PDATA_W-1:0] cfg_pwdata = '0;
  logic [PDATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  complex_arithmetic_unit u_top (.*);

  op_item_t    pending_ops[$];
  alu_result_t expected_results[$];
  op_item_t    cur_op;
  logic [TOL_W-1:0] tolerance = TOL_RESET;
  int send_idle = 0, recv_idle = 0;
  int queued_cnt = 0, accepted_cnt = 0, checked_cnt = 0, mismatch_cnt = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Round a wide Q(2*FB) value to Q(FB), half away from zero.
  function automatic logic signed [127:0] round_q(logic signed [127:0] v);
    logic [127:0] m;
    m = v[127] ? -v : v;
    m = (m + (128'd1 << (FB - 1))) >> FB;
    return v[127] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [127:0] div_q(logic signed [127:0] num,
                                                logic [127:0] den);
    logic [127:0] m;
    m = num[127] ? -num : num;
    m = (((m << (FB + 1)) / den) + 128'd1) >> 1;
    return num[127] ? -$signed(m) : $signed(m);
  endfunction

  // {saturated flag, clamped part}
  function automatic logic [DW:0] clamp_part(logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    if (v < -128'sh8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, v[DW-1:0]};
  endfunction

  function automatic alu_result_t predict_alu(op_item_t op, logic [TOL_W-1:0] tol);
    logic signed [127:0] a, b, c, d, re, im, dr, di;
    logic [127:0] den;
    logic [DW:0] sr, si;
    logic arith;
    alu_result_t r;
    a = op.ar; b = op.ai; c = op.br; d = op.bi;
    r = '0; re = 0; im = 0; arith = 1'b1;
    case (op.kind)
      OP_ADD: begin re = a + c; im = b + d; end
      OP_SUB: begin re = a - c; im = b - d; end
      OP_MUL: begin re = round_q(a * c - b * d); im = round_q(a * d + b * c); end
      OP_DIV: begin
        den = c * c + d * d;
        if (den == 0) begin
          r.dz = 1'b1; arith = 1'b0;
        end else begin
          re = div_q(a * c + b * d, den);
          im = div_q(b * c - a * d, den);
        end
      end
      OP_EQ, OP_NE: begin
        dr = a - c; di = b - d;
        if (dr < 0) dr = -dr;
        if (di < 0) di = -di;
        r.cmp = ((dr < tol) && (di < tol)) ^ (op.kind == OP_NE);
        arith = 1'b0;
      end
      default: arith = 1'b0;
    endcase
    if (arith) begin
      sr = clamp_part(re); si = clamp_part(im);
      r.re = sr[DW-1:0]; r.im = si[DW-1:0]; r.ovf = sr[DW] | si[DW];
    end
    return r;
  endfunction

  // Driver: a new item goes out when the bus is empty or the last was taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_alu(cur_op, tolerance));
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          cur_op = pending_ops.pop_front();
          in_kind <= cur_op.kind;
          in_a_real <= cur_op.ar; in_a_imag <= cur_op.ai;
          in_b_real <= cur_op.br; in_b_imag <= cur_op.bi;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    alu_result_t got, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_res_real, out_res_imag, out_compare_true, out_div_by_zero,
                out_overflow};
        if (expected_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("result with none expected: %h", got);
        end else begin
          want = expected_results.pop_front();
          checked_cnt++;
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"mismatch #%0d: exp re=%h im=%h cmp=%b dz=%b ovf=%b,",
                        " got re=%h im=%h cmp=%b dz=%b ovf=%b"},
                       checked_cnt, want.re, want.im, want.cmp, want.dz, want.ovf,
                       got.re, got.im, got.cmp, got.dz, got.ovf);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  task automatic write_tolerance(logic [TOL_W-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {REG_TOL, 2'b00}; cfg_pwdata <= PDATA_W'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    tolerance = val;
  endtask

  task automatic queue_op(logic [KIND_W-1:0] k, logic [DW-1:0] ar, ai, br, bi);
    pending_ops.push_back('{k, ar, ai, br, bi});
    queued_cnt++;
  endtask

  function automatic logic [DW-1:0] rand_part();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 0;
      3, 4: return $urandom_range(0, 8191) - 4096;
      5, 6: return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random(int n, logic [TOL_W-1:0] tol);
    logic [KIND_W-1:0] k;
    logic [DW-1:0] ar, ai, br, bi;
    repeat (n) begin
      k = ($urandom_range(0, 19) == 0) ? KIND_W'($urandom_range(6, 7))
                                       : KIND_W'($urandom_range(0, 5));
      ar = rand_part(); ai = rand_part(); br = rand_part(); bi = rand_part();
      // compares mostly near the tolerance edge so both outcomes show up
      if ((k == OP_EQ || k == OP_NE) && $urandom_range(0, 3) != 0) begin
        br = ar + $urandom_range(0, 2 * tol + 2) - tol - 1;
        bi = ai + $urandom_range(0, 2 * tol + 2) - tol - 1;
      end
      if (k == OP_DIV && $urandom_range(0, 7) == 0) begin
        br = 0; bi = 0;
      end
      queue_op(k, ar, ai, br, bi);
    end
  endtask

  task automatic drain();
    while (accepted_cnt != queued_cnt || expected_results.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  initial begin
    logic [TOL_W-1:0] tol_set[4];
    tol_set = '{16'd0, 16'd65535, 16'd1, 16'd1};
    tol_set[3] = TOL_W'($urandom_range(2, 65534));
    send_idle = 16; recv_idle = 73;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, every opcode, rounding ties, zero divisor
    queue_op(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    queue_op(OP_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000);
    queue_op(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    queue_op(OP_SUB, 32'h0005_0000, 32'h0, 32'h0002_8000, 32'h0001_0000);
    queue_op(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_op(OP_MUL, 32'h0000_8000, 32'h0, 32'h0000_0001, 32'h0);
    queue_op(OP_MUL, 32'hFFFF_8000, 32'h0, 32'h0000_0001, 32'h0);
    queue_op(OP_MUL, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 32'hFFFF_0000);
    queue_op(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_op(OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
    queue_op(OP_DIV, 32'h0006_0000, 32'h0002_0000, 32'h0002_0000, 32'h0);
    queue_op(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0);
    queue_op(OP_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);
    queue_op(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_op(OP_DIV, 32'h0000_0001, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_op(OP_EQ, 32'h0001_0000, 32'h2, 32'h0001_0000, 32'h2);
    queue_op(OP_EQ, 32'h0001_0000, 32'h2, 32'h0001_0001, 32'h2);
    queue_op(OP_EQ, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
    queue_op(OP_NE, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_op(OP_NE, 32'h0, 32'h0, 32'h0, 32'h1);
    queue_op(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(3'd7, 32'h1234_5678, 32'h0, 32'h0, 32'h0);
    queue_random(40, tolerance);
    drain();
    foreach (tol_set[i]) begin
      write_tolerance(tol_set[i]);
      // sender-light first, then receiver-light, then full rate
      if (i == 0) begin
        send_idle = 16; recv_idle = 73;
      end else if (i < 3) begin
        send_idle = 73; recv_idle = 16;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      queue_op(OP_EQ, 32'h10, 32'h10, 32'h10, 32'h10);
      queue_op(OP_NE, 32'h10, 32'h10, 32'h10, 32'h10);
      queue_random(335, tol_set[i]);
      drain();
    end
    $display("%0d items checked over all six opcodes plus unused codes,", checked_cnt);
    $display("tolerance settings 1, 0, 65535 and random, with stalls on both sides.");
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/cau_pkg.sv
rtl/core/complex_arithmetic_unit.sv
verif/tb_complex_arithmetic_unit.sv
